FILE: hw/rtl/rab_pkg.sv
// Shared constants and types for the region adjacency builder.
package rab_pkg;

    localparam int MAX_REGIONS = 64;
    localparam int MAX_WIDTH   = 2048;

    localparam int LABEL_W  = $clog2(MAX_REGIONS);
    localparam int COUNT_W  = LABEL_W + 1;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int CFG_W_W  = 12;
    localparam int MASK_W   = MAX_REGIONS;

    // Register indexes, decoded from paddr[2]
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_REGION_COUNT = 1'b1;

    typedef enum logic
    {
        ST_RUN,
        ST_EMIT
    } state_t;

    // One pixel's marking request towards the matrix
    typedef struct packed
    {
        logic [LABEL_W-1:0] label;
        logic [LABEL_W-1:0] left;
        logic               left_hit;
        logic [LABEL_W-1:0] above;
        logic               above_hit;
    } mark_t;

    // Matrix control from the report sequencer
    typedef struct packed
    {
        logic shift;
        logic clear;
    } mat_ctl_t;

endpackage

FILE: hw/rtl/region_adjacency_builder.sv
// Top level of the region adjacency builder: pixel pipeline, line buffer, report sequencer.
// Usage
//   Slave stream: one beat per pixel in raster order. s_tdata[5:0] is the region
//   label, s_tlast marks the last pixel of the frame. Pixels are taken one per
//   cycle while a frame is streaming.
//   Each pixel is compared with its left neighbour and with the pixel above it
//   (previous row, held in a 2048-entry line buffer with a registered read);
//   differing labels below region_count mark both matrix rows. A pixel passes
//   through the stage-1 registers before it is marked into the matrix.
//   On the frame's last pixel the slave side stalls, and the matrix is reported
//   on the master stream as one beat per region 0..region_count-1: m_tdata[5:0]
//   row_region, m_tdata[69:6] neighbour mask, m_tlast on the final region. The
//   report starts once the last pixel has passed the stage-1 registers and the
//   sequencer has entered its emit state, and runs one beat per cycle while
//   m_tready is high; a stalled receiver holds the beat in the output register
//   and pauses the report. Pixels are accepted again once the last report beat
//   has been loaded.
//   Reset clears the matrix, the position counters and the output valid flag; the
//   line buffer is not cleared, unwritten entries are never used.
//   APB: image_width at 0x0, region_count at 0x4; write only while idle.
module region_adjacency_builder
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [5:0] region_label, [7:6] unused
    input  logic        s_tlast,   // end_of_frame

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [5:0] row_region, [69:6] neighbor_mask, [71:70] zero
    output logic        m_tlast,   // last_row

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LW = rab_pkg::LABEL_W;
    localparam int CW = rab_pkg::COL_W;
    localparam int NW = rab_pkg::COUNT_W;
    localparam int WW = rab_pkg::CFG_W_W;

    // ---------------- configuration ----------------
    logic [WW-1:0] image_width_reg;
    logic [NW-1:0] region_count_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WW'(640);
            region_count_reg <= NW'(64);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                rab_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[WW-1:0];
                rab_pkg::REG_REGION_COUNT: region_count_reg <= pwdata[NW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            rab_pkg::REG_IMAGE_WIDTH:  prdata = 32'(image_width_reg);
            rab_pkg::REG_REGION_COUNT: prdata = 32'(region_count_reg);
            default:                   prdata = '0;
        endcase
    end

    // Effective width and region count after saturation
    logic [WW-1:0] eff_width;
    logic [NW-1:0] eff_regions;

    always_comb
    begin
        if (image_width_reg == '0)
        begin
            eff_width = WW'(1);
        end
        else if (image_width_reg > WW'(rab_pkg::MAX_WIDTH))
        begin
            eff_width = WW'(rab_pkg::MAX_WIDTH);
        end
        else
        begin
            eff_width = image_width_reg;
        end

        if (region_count_reg > NW'(rab_pkg::MAX_REGIONS))
        begin
            eff_regions = NW'(rab_pkg::MAX_REGIONS);
        end
        else
        begin
            eff_regions = region_count_reg;
        end
    end

    // ---------------- stage 0: position tracking ----------------
    rab_pkg::state_t state_reg, state_next;

    logic          p1_valid_reg;
    logic          p1_eof_reg;
    logic          in_beat;

    logic [CW-1:0] col_pos_reg,    col_pos_next;
    logic [WW-1:0] prev_len_reg,   prev_len_next;
    logic          first_row_reg,  first_row_next;
    logic [LW-1:0] left_label_reg, left_label_next;

    logic [CW-1:0] col;
    logic [WW-1:0] col_inc;
    logic [WW-1:0] prev_len_eff;
    logic          first_row_eff;
    logic          left_ok;
    logic          above_ok;
    logic [LW-1:0] label_in;

    assign label_in = s_tdata[LW-1:0];
    assign s_tready = (state_reg == rab_pkg::ST_RUN) && !(p1_valid_reg && p1_eof_reg);
    assign in_beat  = s_tvalid && s_tready;

    always_comb
    begin
        // Wrap at once if the width was lowered below the current column
        if (WW'(col_pos_reg) >= eff_width)
        begin
            col           = '0;
            prev_len_eff  = WW'(col_pos_reg);
            first_row_eff = 1'b0;
        end
        else
        begin
            col           = col_pos_reg;
            prev_len_eff  = prev_len_reg;
            first_row_eff = first_row_reg;
        end

        col_inc  = WW'(col) + WW'(1);
        left_ok  = (col != '0);
        above_ok = !first_row_eff && (WW'(col) < prev_len_eff);

        col_pos_next    = col_pos_reg;
        prev_len_next   = prev_len_reg;
        first_row_next  = first_row_reg;
        left_label_next = left_label_reg;

        if (in_beat)
        begin
            priority if (s_tlast)
            begin
                col_pos_next    = '0;
                prev_len_next   = '0;
                first_row_next  = 1'b1;
                left_label_next = '0;
            end
            else if (col_inc >= eff_width)
            begin
                col_pos_next    = '0;
                prev_len_next   = col_inc;
                first_row_next  = 1'b0;
                left_label_next = label_in;
            end
            else
            begin
                col_pos_next    = col_inc[CW-1:0];
                prev_len_next   = prev_len_eff;
                first_row_next  = first_row_eff;
                left_label_next = label_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg    <= '0;
            prev_len_reg   <= '0;
            first_row_reg  <= 1'b1;
            left_label_reg <= '0;
            p1_valid_reg   <= 1'b0;
            p1_eof_reg     <= 1'b0;
        end
        else
        begin
            col_pos_reg    <= col_pos_next;
            prev_len_reg   <= prev_len_next;
            first_row_reg  <= first_row_next;
            left_label_reg <= left_label_next;
            p1_valid_reg   <= in_beat;
            p1_eof_reg     <= in_beat && s_tlast;
        end
    end

    // Pixel payload for stage 1
    logic [LW-1:0] p1_label_reg;
    logic [LW-1:0] p1_left_reg;
    logic          p1_left_ok_reg;
    logic          p1_above_ok_reg;

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            p1_label_reg    <= label_in;
            p1_left_reg     <= left_label_reg;
            p1_left_ok_reg  <= left_ok;
            p1_above_ok_reg <= above_ok;
        end
    end

    // Line buffer: read the row above and overwrite it with this pixel
    logic [LW-1:0] line_buf [rab_pkg::MAX_WIDTH];
    logic [LW-1:0] above_label_reg;

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            above_label_reg <= line_buf[col];
            line_buf[col]   <= label_in;
        end
    end

    // ---------------- stage 1: mark the matrix ----------------
    rab_pkg::mark_t    mark;
    rab_pkg::mat_ctl_t mat_ctl;
    logic [rab_pkg::MASK_W-1:0] head_row;

    logic label_in_use;

    always_comb
    begin
        label_in_use   = NW'(p1_label_reg) < eff_regions;
        mark.label     = p1_label_reg;
        mark.left      = p1_left_reg;
        mark.above     = above_label_reg;
        mark.left_hit  = p1_valid_reg && p1_left_ok_reg && label_in_use
                         && (NW'(p1_left_reg) < eff_regions)
                         && (p1_left_reg != p1_label_reg);
        mark.above_hit = p1_valid_reg && p1_above_ok_reg && label_in_use
                         && (NW'(above_label_reg) < eff_regions)
                         && (above_label_reg != p1_label_reg);
    end

    rab_adj_matrix u_matrix
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .mark     (mark),
        .ctl      (mat_ctl),
        .head_row (head_row)
    );

    // ---------------- report sequencer ----------------
    logic [LW-1:0] row_idx_reg, row_idx_next;
    logic          out_valid_reg;
    logic [LW-1:0] out_region_reg;
    logic [rab_pkg::MASK_W-1:0] out_mask_reg;
    logic          out_last_reg;

    logic emit_go;
    logic emit_last;
    logic frame_done;

    assign frame_done = p1_valid_reg && p1_eof_reg;
    assign emit_go    = (state_reg == rab_pkg::ST_EMIT) && (!out_valid_reg || m_tready);
    assign emit_last  = (NW'(row_idx_reg) + NW'(1)) == eff_regions;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rab_pkg::ST_RUN:
            begin
                if (frame_done && eff_regions != '0)
                begin
                    state_next = rab_pkg::ST_EMIT;
                end
            end
            rab_pkg::ST_EMIT:
            begin
                if (emit_go && emit_last)
                begin
                    state_next = rab_pkg::ST_RUN;
                end
            end
            default: state_next = rab_pkg::ST_RUN;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        mat_ctl.shift = 1'b0;
        mat_ctl.clear = 1'b0;
        row_idx_next  = row_idx_reg;
        unique case (state_reg)
            rab_pkg::ST_RUN:
            begin
                row_idx_next  = '0;
                // No regions to report: drop the matrix straight away
                mat_ctl.clear = frame_done && (eff_regions == '0);
            end
            rab_pkg::ST_EMIT:
            begin
                if (emit_go)
                begin
                    mat_ctl.shift = 1'b1;
                    mat_ctl.clear = emit_last;
                    row_idx_next  = row_idx_reg + LW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rab_pkg::ST_RUN;
            row_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_idx_reg <= row_idx_next;
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output beat register: hold while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            out_region_reg <= row_idx_reg;
            out_mask_reg   <= head_row;
            out_last_reg   <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_mask_reg, out_region_reg};
    assign m_tlast  = out_last_reg;

endmodule

FILE: hw/rtl/rab_adj_matrix.sv
// Adjacency bit matrix: marks pairs per pixel, shifts rows out for the report.
module rab_adj_matrix
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  rab_pkg::mark_t              mark,
    input  rab_pkg::mat_ctl_t           ctl,
    output logic [rab_pkg::MASK_W-1:0]  head_row
);

    logic [rab_pkg::MASK_W-1:0] rows_reg  [rab_pkg::MAX_REGIONS];
    logic [rab_pkg::MASK_W-1:0] rows_next [rab_pkg::MAX_REGIONS];

    logic [rab_pkg::MASK_W-1:0] own_bits;
    logic [rab_pkg::MASK_W-1:0] label_bit;

    always_comb
    begin
        label_bit = rab_pkg::MASK_W'(1) << mark.label;
        own_bits  = '0;
        if (mark.left_hit)
        begin
            own_bits = own_bits | (rab_pkg::MASK_W'(1) << mark.left);
        end
        if (mark.above_hit)
        begin
            own_bits = own_bits | (rab_pkg::MASK_W'(1) << mark.above);
        end
    end

    always_comb
    begin
        for (int r = 0; r < rab_pkg::MAX_REGIONS; r++)
        begin
            rows_next[r] = rows_reg[r];
            priority if (ctl.clear)
            begin
                rows_next[r] = '0;
            end
            else if (ctl.shift)
            begin
                if (r == rab_pkg::MAX_REGIONS - 1)
                begin
                    rows_next[r] = '0;
                end
                else
                begin
                    rows_next[r] = rows_reg[r + 1];
                end
            end
            else
            begin
                if (mark.label == rab_pkg::LABEL_W'(r))
                begin
                    rows_next[r] = rows_next[r] | own_bits;
                end
                if (mark.left_hit && mark.left == rab_pkg::LABEL_W'(r))
                begin
                    rows_next[r] = rows_next[r] | label_bit;
                end
                if (mark.above_hit && mark.above == rab_pkg::LABEL_W'(r))
                begin
                    rows_next[r] = rows_next[r] | label_bit;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < rab_pkg::MAX_REGIONS; r++)
            begin
                rows_reg[r] <= '0;
            end
        end
        else
        begin
            for (int r = 0; r < rab_pkg::MAX_REGIONS; r++)
            begin
                rows_reg[r] <= rows_next[r];
            end
        end
    end

    assign head_row = rows_reg[0];

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the region adjacency builder: pixel stream in, adjacency report out.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Pixel beats that the random part aims for, cycles of silence before a register
    // write, drain time at the end and the watchdog's limit on silent cycles.
    localparam int unsigned RANDOM_PIXELS = 130;
    localparam int unsigned QUIET_CYCLES  = 8;
    localparam int unsigned TAIL_CYCLES   = 80;
    localparam int unsigned STALL_LIMIT   = 2000;

    typedef enum logic [1:0]
    {
        OP_PIXEL,
        OP_SET_WIDTH,
        OP_SET_COUNT
    } op_e;

    // One row of the directed script. On a typed row, region k of the report must
    // carry masks[4k+3:4k] for k < 4 and an empty mask above.
    typedef struct packed
    {
        op_e         op;
        logic [11:0] val;
        logic        eof;
        logic        typed;
        logic [15:0] masks;
    } stim_row_t;

    // One beat of the report: a region and the set of regions touching it
    typedef struct
    {
        logic [5:0]  region;
        logic [63:0] mask;
        logic        last;
    } report_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [5:0] region_label, [7:6] zero
    logic        s_tlast;   // end_of_frame
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // [5:0] row_region, [69:6] neighbor_mask, [71:70] zero
    logic        m_tlast;   // last_row
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the block: adjacency rows, line buffer, raster position, registers
    logic [63:0] adj_rows [rab_pkg::MAX_REGIONS];
    logic [5:0]  line_buf [rab_pkg::MAX_WIDTH];
    logic [5:0]  left_lbl;
    int unsigned col_pos;
    int unsigned above_len;
    bit          first_row;
    logic [11:0] cfg_width;
    logic [6:0]  cfg_count;

    // Report beats still owed by the block, oldest first
    report_t     report_queue [$];

    int unsigned errors;
    int unsigned rows_checked;
    int unsigned pixels_sent;
    int unsigned frames_sent;
    int unsigned reg_writes;
    bit          feed_burst;
    bit          sink_burst;

    stim_row_t script [31] = '{
        // after reset: a lone pixel, 64 empty rows
        '{OP_PIXEL,     12'd0,    1'b1, 1'b1, 16'h0000},
        // 2x2 frame of four regions: every pair but the diagonals touches
        '{OP_SET_WIDTH, 12'd2,    1'b0, 1'b0, 16'h0000},
        '{OP_SET_COUNT, 12'd4,    1'b0, 1'b0, 16'h0000},
        '{OP_PIXEL,     12'd0,    1'b0, 1'b0, 16'h0000},
        '{OP_PIXEL,     12'd1,    1'b0, 1'b0, 16'h0000},
        '{OP_PIXEL,     12'd2,    1'b0, 1'b0, 16'h0000},
        '{OP_PIXEL,     12'd3,    1'b1, 1'b1, 16'h6996},
        // label out of use next to a live one: only 0-1 is marked
        '{OP_SET_WIDTH, 12'd3,    1'b0, 1'b0, 16'h0000},
        '{OP_SET_COUNT, 12'd2,    1'b0, 1'b0, 16'h0000},
        '{OP_PIXEL,     12'd63,   1'b0, 1'b0, 16'h0000},
        '{OP_PIXEL,     12'd0,    1'b0, 1'b0, 16'h0000},
        '{OP_PIXEL,     12'd1,    1'b1, 1'b1, 16'h0012},
        // no regions in use: the frame ends with no report at all
        '{OP_SET_COUNT, 12'd0,    1'b0, 1'b0, 16'h0000},
        '{OP_PIXEL,     12'd5,    1'b0, 1'b0, 16'h0000},
        '{OP_PIXEL,     12'd7,    1'b1, 1'b1, 16'h0000},
        // zero width behaves as one column, oversized count saturates
        '{OP_SET_WIDTH, 12'd0,    1'b0, 1'b0, 16'h0000},
        '{OP_SET_COUNT, 12'd127,  1'b0, 1'b0, 16'h0000},
        '{OP_PIXEL,     12'd10,   1'b0, 1'b0, 16'h0000},
        '{OP_PIXEL,     12'd20,   1'b0, 1'b0, 16'h0000},
        '{OP_PIXEL,     12'd10,   1'b1, 1'b0, 16'h0000},
        // widest setting, then narrowed mid-row so the row wraps at once
        '{OP_SET_WIDTH, 12'd4095, 1'b0, 1'b0, 16'h0000},
        '{OP_SET_COUNT, 12'd64,   1'b0, 1'b0, 16'h0000},
        '{OP_PIXEL,     12'd1,    1'b0, 1'b0, 16'h0000},
        '{OP_PIXEL,     12'd2,    1'b0, 1'b0, 16'h0000},
        '{OP_PIXEL,     12'd3,    1'b0, 1'b0, 16'h0000},
        '{OP_PIXEL,     12'd4,    1'b0, 1'b0, 16'h0000},
        '{OP_PIXEL,     12'd5,    1'b0, 1'b0, 16'h0000},
        '{OP_SET_WIDTH, 12'd3,    1'b0, 1'b0, 16'h0000},
        '{OP_PIXEL,     12'd5,    1'b0, 1'b0, 16'h0000},
        '{OP_PIXEL,     12'd1,    1'b0, 1'b0, 16'h0000},
        '{OP_PIXEL,     12'd42,   1'b1, 1'b0, 16'h0000}
    };

    region_adjacency_builder dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    // Saturate the count register to the matrix size
    function automatic int unsigned regions_in_use();
        return (int'(cfg_count) > rab_pkg::MAX_REGIONS) ? rab_pkg::MAX_REGIONS
                                                         : int'(cfg_count);
    endfunction

    // Zero width acts as one column; oversized widths clamp to the line buffer
    function automatic int unsigned width_in_use();
        if (cfg_width == 12'd0)
            return 1;
        return (int'(cfg_width) > rab_pkg::MAX_WIDTH) ? rab_pkg::MAX_WIDTH
                                                       : int'(cfg_width);
    endfunction

    // Mark both directions, but only for two distinct labels that are in use
    function automatic void link_regions(int unsigned a, int unsigned b, int unsigned n);
        if (a == b || a >= n || b >= n)
            return;
        adj_rows[a][b] = 1'b1;
        adj_rows[b][a] = 1'b1;
    endfunction

    function automatic void clear_frame();
        foreach (adj_rows[i])
            adj_rows[i] = '0;
        left_lbl  = '0;
        col_pos   = 0;
        above_len = 0;
        first_row = 1'b1;
    endfunction

    // Advance the shadow by one accepted pixel; on the frame's last pixel queue one
    // report beat per region in use and start a fresh frame.
    function automatic int unsigned account_pixel(logic [5:0] lbl, logic eof);
        int unsigned n;
        int unsigned w;
        int unsigned col;
        report_t     beat;
        n = regions_in_use();
        w = width_in_use();
        // width lowered while mid-row: wrap before this pixel
        if (col_pos >= w)
        begin
            above_len = (col_pos < rab_pkg::MAX_WIDTH) ? col_pos : rab_pkg::MAX_WIDTH;
            col_pos   = 0;
            first_row = 1'b0;
        end
        col = col_pos;
        if (col > 0)
            link_regions(lbl, left_lbl, n);
        // compare upwards only where the previous row reached this column
        if (!first_row && col < above_len)
            link_regions(lbl, line_buf[col], n);
        line_buf[col] = lbl;
        left_lbl      = lbl;
        col_pos       = col + 1;
        if (col_pos >= w)
        begin
            above_len = col_pos;
            col_pos   = 0;
            first_row = 1'b0;
        end
        if (!eof)
            return 0;
        for (int unsigned k = 0; k < n; k++)
        begin
            beat.region = 6'(k);
            beat.mask   = adj_rows[k];
            beat.last   = (k + 1 == n);
            report_queue.insert(report_queue.size(), beat);
        end
        clear_frame();
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Mostly back-to-back, some short gaps, the odd long one
    function automatic int unsigned pick_gap(bit burst);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Present one pixel beat, hold it until taken, and feed it to the shadow.
    // Enter and leave at a falling edge.
    task automatic send_pixel(input logic [5:0] lbl, input logic eof, output int unsigned made);
        int unsigned gap;
        gap = pick_gap(feed_burst);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, lbl};
        s_tlast  = eof;
        do
            @(posedge clk);
        while (!s_tready);
        made = account_pixel(lbl, eof);
        pixels_sent++;
        if (eof)
            frames_sent++;
        @(negedge clk);
    endtask

    // Drop the pixel stream, wait for every owed report beat, then let the pipeline
    // run dry. Leave at a falling edge.
    task automatic settle();
        s_tvalid = 1'b0;
        while (report_queue.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Write a register once the block is idle, then read it back
    task automatic program_reg(input logic sel, input logic [31:0] value);
        settle();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {sel, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (sel == rab_pkg::REG_IMAGE_WIDTH)
            cfg_width = value[11:0];
        else
            cfg_count = value[6:0];
        reg_writes++;
        @(negedge clk);
        // back-to-back read of the same register
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== value)
        begin
            errors++;
            $display("%0t readback at 0x%0h: expected 0x%0h, got 0x%0h",
                     $time, paddr, value, prdata);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic logic [11:0] pick_width();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)  return 12'd0;
        if (r < 10) return 12'd1;
        if (r < 14) return 12'd2048;
        if (r < 18) return 12'd4095;
        if (r < 22) return 12'($urandom_range(2049, 4094));
        if (r < 26) return 12'($urandom_range(9, 2047));
        return 12'($urandom_range(2, 8));
    endfunction

    function automatic logic [6:0] pick_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)  return 7'd64;
        if (r < 12) return 7'd0;
        if (r < 18) return 7'($urandom_range(65, 127));
        if (r < 24) return 7'd1;
        if (r < 30) return 7'($urandom_range(13, 63));
        return 7'($urandom_range(2, 12));
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, with stretches of none
    // ------------------------------------------------------------------
    initial
    begin : sink_pacing
        int unsigned hold;
        int unsigned r;
        hold     = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else
            begin
                r = $urandom_range(0, 99);
                if (sink_burst || r < 65)
                begin
                    m_tready = 1'b1;
                    hold     = $urandom_range(0, 6);
                end
                else
                begin
                    m_tready = 1'b0;
                    hold     = (r < 92) ? $urandom_range(0, 2) : $urandom_range(5, 25);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Report checker: every accepted beat against the oldest owed one
    // ------------------------------------------------------------------
    initial
    begin : report_check
        report_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (report_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected report beat: region %0d mask 0x%016h last %0b",
                             $time, m_tdata[5:0], m_tdata[69:6], m_tlast);
                end
                else
                begin
                    want = report_queue.pop_front();
                    rows_checked++;
                    if (m_tdata[5:0] !== want.region)
                    begin
                        errors++;
                        $display("%0t row_region: expected %0d, got %0d",
                                 $time, want.region, m_tdata[5:0]);
                    end
                    if (m_tdata[69:6] !== want.mask)
                    begin
                        errors++;
                        $display("%0t neighbor_mask of region %0d: expected 0x%016h, got 0x%016h",
                                 $time, want.region, want.mask, m_tdata[69:6]);
                    end
                    if (m_tlast !== want.last)
                    begin
                        errors++;
                        $display("%0t last_row of region %0d: expected %0b, got %0b",
                                 $time, want.region, want.last, m_tlast);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if neither stream moves for too long
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t watchdog: no beat for %0d cycles, %0d report beats still owed",
                 $time, STALL_LIMIT, report_queue.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned made;
        int unsigned slot;
        int unsigned len;
        int unsigned split;
        int unsigned w_use;
        int unsigned hi;
        int unsigned r;
        int unsigned random_start;
        logic [5:0]  palette [4];
        logic [5:0]  lbl;
        bit          noisy;

        // Hold every input at a known value through reset
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        feed_burst = 1'b0;
        sink_burst = 1'b0;
        errors       = 0;
        rows_checked = 0;
        pixels_sent  = 0;
        frames_sent  = 0;
        reg_writes   = 0;
        lbl          = '0;

        // Shadow starts from the reset values of the registers
        cfg_width = 12'd640;
        cfg_count = 7'd64;
        clear_frame();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed script. Typed rows overwrite the masks just queued by the shadow
        // with values read straight off the frame.
        foreach (script[i])
        begin
            case (script[i].op)
                OP_SET_WIDTH: program_reg(rab_pkg::REG_IMAGE_WIDTH, 32'(script[i].val));
                OP_SET_COUNT: program_reg(rab_pkg::REG_REGION_COUNT, 32'(script[i].val));
                default:
                begin
                    send_pixel(script[i].val[5:0], script[i].eof, made);
                    if (script[i].typed)
                    begin
                        for (int unsigned j = 0; j < made; j++)
                        begin
                            slot = report_queue.size() - made + j;
                            report_queue[slot].mask = (j < 4) ?
                                64'(script[i].masks[4*j +: 4]) : 64'd0;
                        end
                    end
                end
            endcase
        end

        // Random frames: mostly rectangular frames built from a small palette so
        // regions form runs and blobs; some frames end mid-row, some are pure noise,
        // and a few have their width changed part-way through.
        random_start = pixels_sent;
        while (pixels_sent - random_start < RANDOM_PIXELS)
        begin
            feed_burst = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 0)
            begin
                program_reg(rab_pkg::REG_IMAGE_WIDTH, 32'(pick_width()));
                program_reg(rab_pkg::REG_REGION_COUNT, 32'(pick_count()));
            end
            w_use = width_in_use();
            if (w_use > 16)
                len = $urandom_range(1, 12);
            else
            begin
                len = w_use * $urandom_range(1, 6);
                if (len > 48)
                    len = 48;
                if ($urandom_range(0, 4) == 0)
                    len = $urandom_range(1, len);
            end
            split = (len > 1 && $urandom_range(0, 6) == 0) ? $urandom_range(1, len - 1) : 0;
            hi    = (regions_in_use() == 0) ? 63 : regions_in_use() - 1;
            foreach (palette[p])
                palette[p] = 6'($urandom_range(0, hi));
            noisy = ($urandom_range(0, 6) == 0);

            for (int unsigned i = 0; i < len; i++)
            begin
                if (split != 0 && i == split)
                begin
                    // change the geometry between two pixels of the same frame
                    program_reg(rab_pkg::REG_IMAGE_WIDTH, 32'($urandom_range(1, 8)));
                    if ($urandom_range(0, 2) == 0)
                        program_reg(rab_pkg::REG_REGION_COUNT, 32'(pick_count()));
                end
                r = $urandom_range(0, 99);
                if (noisy || r < 8)
                    lbl = 6'($urandom_range(0, 63));
                else if (r < 50 && i > 0)
                    lbl = lbl;
                else
                    lbl = palette[$urandom_range(0, 3)];
                send_pixel(lbl, i == len - 1, made);
            end
        end

        // Drain: every owed beat, then a margin to catch stray ones
        s_tvalid = 1'b0;
        while (report_queue.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d pixel beats in %0d frames with %0d register writes;",
                 pixels_sent, frames_sent, reg_writes);
        $display("checked %0d report beats, %0d mismatches.", rows_checked, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
